@@ hdl/bdeq_pkg.sv @@
// Shared types and constants for the bounded double-ended queue.
// Holds operation codes, status codes and payload widths; no dependencies.
package bdeq_pkg;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request operations
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_LIST       = 3'd4;

  // result status
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

@@ hdl/bdeq_store.sv @@
// Value store of the queue: one write port and one read port, registered read.
// Depends on bdeq_pkg for the data type.
module bdeq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  bdeq_pkg::data_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output bdeq_pkg::data_t rd_data
);

  bdeq_pkg::data_t mem [DEPTH];
  bdeq_pkg::data_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/bounded_double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit words over a circular store.
// Push, pop and unused modes give one result word: accept, then the result
// is loaded into the output register; a pop reads the store at accept time.
// A list of N >= 1 stored words gives N result words, one store read per result word;
// a list of an empty queue answers like an empty pop; output stalls hold results.
// Synchronous active-low reset empties the queue and drops any pending result;
// store contents are not cleared.
module bounded_double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] value
  input  logic [2:0]                  in_tuser,   // [2:0] mode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // [31:0] item
  output logic [1:0]                  out_tuser,  // [1:0] status
  output logic                        out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ONE  = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_X   = (CW+1)'(DEPTH);

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] lst_addr_r, lst_addr_nxt;
  logic [CW-1:0] lst_left_r, lst_left_nxt;
  logic          out_valid_r, out_valid_nxt;

  // per-request result fields
  bdeq_pkg::status_t res_status_r, res_status_nxt;
  logic              res_mem_r, res_mem_nxt;

  // output register
  bdeq_pkg::data_t   out_item_r;
  bdeq_pkg::status_t out_status_r;
  logic              out_last_r;

  // store port
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  bdeq_pkg::data_t rd_data;

  logic          accept, slot_free, emit, emit_last;
  logic          full, empty;
  logic [AW-1:0] front_inc, front_dec, tail_slot, back_slot, lst_inc;
  logic [CW:0]   tail_sum, back_sum;
  bdeq_pkg::data_t emit_item;

  bdeq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign full      = (occ_r == CW'(DEPTH));
  assign empty     = (occ_r == '0);

  // circular slot arithmetic, every sum stays below twice the depth on a non-empty queue
  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
  assign lst_inc   = (lst_addr_r == LAST_SLOT) ? '0 : lst_addr_r + 1'b1;
  assign tail_sum  = (CW+1)'(front_r) + (CW+1)'(occ_r);
  assign back_sum  = (CW+1)'(front_r) + (CW+1)'(occ_r) - 1'b1;
  assign tail_slot = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
  assign back_slot = (back_sum >= DEPTH_X) ? AW'(back_sum - DEPTH_X) : AW'(back_sum);

  // result word selection
  assign emit      = slot_free && ((state_r == S_ONE) || (state_r == S_LIST));
  assign emit_last = (state_r == S_ONE) || (lst_left_r == CW'(1));
  assign emit_item = ((state_r == S_LIST) || res_mem_r) ? rd_data : '0;

  // request decode, pointer update and list sequencing
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    lst_addr_nxt   = lst_addr_r;
    lst_left_nxt   = lst_left_r;
    res_status_nxt = res_status_r;
    res_mem_nxt    = res_mem_r;
    wr_en          = 1'b0;
    wr_addr        = tail_slot;
    rd_en          = 1'b0;
    rd_addr        = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt      = S_ONE;
          res_status_nxt = bdeq_pkg::ST_OK;
          res_mem_nxt    = 1'b0;
          unique case (in_tuser)
            bdeq_pkg::MODE_PUSH_FRONT: begin
              if (full) begin
                res_status_nxt = bdeq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                occ_nxt   = occ_r + 1'b1;
              end
            end
            bdeq_pkg::MODE_PUSH_BACK: begin
              if (full) begin
                res_status_nxt = bdeq_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = tail_slot;
                occ_nxt = occ_r + 1'b1;
              end
            end
            bdeq_pkg::MODE_POP_FRONT: begin
              if (empty) begin
                res_status_nxt = bdeq_pkg::ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = front_r;
                res_mem_nxt = 1'b1;
                front_nxt   = front_inc;
                occ_nxt     = occ_r - 1'b1;
              end
            end
            bdeq_pkg::MODE_POP_BACK: begin
              if (empty) begin
                res_status_nxt = bdeq_pkg::ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = back_slot;
                res_mem_nxt = 1'b1;
                occ_nxt     = occ_r - 1'b1;
              end
            end
            bdeq_pkg::MODE_LIST: begin
              if (empty) begin
                res_status_nxt = bdeq_pkg::ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = front_r;
                lst_addr_nxt = front_inc;
                lst_left_nxt = occ_r;
                state_nxt    = S_LIST;
              end
            end
            default: begin
              // unused modes answer ok with no effect
              res_status_nxt = bdeq_pkg::ST_OK;
            end
          endcase
        end
      end
      S_ONE: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        if (emit) begin
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = lst_addr_r;
            lst_addr_nxt = lst_inc;
            lst_left_nxt = lst_left_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lst_addr_r   <= lst_addr_nxt;
    lst_left_r   <= lst_left_nxt;
    res_status_r <= res_status_nxt;
    res_mem_r    <= res_mem_nxt;
    if (emit) begin
      out_item_r   <= emit_item;
      out_status_r <= (state_r == S_LIST) ? bdeq_pkg::ST_OK : res_status_r;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for bounded_double_ended_queue.
// Depends on bdeq_pkg for the op/status codes and the RTL top; a local
// mirror of the deque predicts every reply word but those of typed plan steps.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int PLAN_LEN   = 20;
  localparam int PHASE_LEN  = 49;
  localparam int BURST_LEN  = 24;

  // modes with no operation behind them
  localparam bdeq_pkg::mode_t MODE_SPARE_A = 3'd5;
  localparam bdeq_pkg::mode_t MODE_SPARE_B = 3'd6;
  localparam bdeq_pkg::mode_t MODE_SPARE_C = 3'd7;

  typedef struct packed {
    bdeq_pkg::data_t   item;
    bdeq_pkg::status_t status;
    logic              last;
  } reply_t;

  // directed step: reps > 1 repeats the mode with values base, base+1 and so on
  typedef struct packed {
    bdeq_pkg::mode_t   mode;
    bdeq_pkg::data_t   value;
    logic [4:0]        reps;
    logic              typed;
    bdeq_pkg::data_t   exp_item;
    bdeq_pkg::status_t exp_status;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  // deque mirror
  bdeq_pkg::data_t mirror_store [DEPTH];
  int     mirror_front = 0;
  int     mirror_count = 0;
  reply_t fresh_replies[$];
  reply_t queued_replies[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int err_count = 0;
  int idle_cycles = 0;
  int req_count = 0;
  int list_count = 0;
  int full_count = 0;
  int empty_count = 0;
  int word_count = 0;

  step_row_t plan [0:PLAN_LEN-1] = '{
    '{bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_EMPTY},
    '{bdeq_pkg::MODE_POP_BACK,   32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_EMPTY},
    '{bdeq_pkg::MODE_LIST,       32'h0000_0000, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_EMPTY},
    '{MODE_SPARE_A,              32'h1234_5678, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_OK},
    '{MODE_SPARE_B,              32'h0000_0000, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_OK},
    '{MODE_SPARE_C,              32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_PUSH_BACK,  32'h7FFF_FFFF, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_LIST,       32'h0000_0000, 5'd1,  1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_PUSH_BACK,  32'hFFFF_FFF0, 5'd16, 1'b1, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_PUSH_FRONT, 32'h5555_5555, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_FULL},
    '{bdeq_pkg::MODE_PUSH_BACK,  32'hAAAA_AAAA, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_FULL},
    '{bdeq_pkg::MODE_LIST,       32'h0000_0000, 5'd1,  1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd3,  1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_PUSH_FRONT, 32'h1234_5678, 5'd3,  1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_LIST,       32'h0000_0000, 5'd1,  1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_POP_BACK,   32'h0000_0000, 5'd16, 1'b0, 32'h0, bdeq_pkg::ST_OK},
    '{bdeq_pkg::MODE_POP_BACK,   32'h0000_0000, 5'd1,  1'b1, 32'h0, bdeq_pkg::ST_EMPTY}
  };

  bounded_double_ended_queue #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] value
    .in_tuser   (in_tuser),   // [2:0] mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] item
    .out_tuser  (out_tuser),  // [1:0] status
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void add_reply(bdeq_pkg::data_t item, bdeq_pkg::status_t status,
                                    logic last);
    reply_t r;
    r.item = item;
    r.status = status;
    r.last = last;
    fresh_replies.push_back(r);
    if (status == bdeq_pkg::ST_FULL) full_count++;
    if (status == bdeq_pkg::ST_EMPTY) empty_count++;
  endfunction

  // Apply one request to the mirror and leave its reply words in fresh_replies.
  function automatic void predict_replies(bdeq_pkg::mode_t mode, bdeq_pkg::data_t value);
    int slot;
    fresh_replies.delete();
    req_count++;
    case (mode) inside
      bdeq_pkg::MODE_PUSH_FRONT, bdeq_pkg::MODE_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          add_reply('0, bdeq_pkg::ST_FULL, 1'b1);
        end else begin
          if (mode == bdeq_pkg::MODE_PUSH_FRONT) begin
            mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
            slot = mirror_front;
          end else begin
            slot = (mirror_front + mirror_count) % DEPTH;
          end
          mirror_store[slot] = value;
          mirror_count++;
          add_reply('0, bdeq_pkg::ST_OK, 1'b1);
        end
      end
      bdeq_pkg::MODE_POP_FRONT, bdeq_pkg::MODE_POP_BACK: begin
        if (mirror_count == 0) begin
          add_reply('0, bdeq_pkg::ST_EMPTY, 1'b1);
        end else if (mode == bdeq_pkg::MODE_POP_FRONT) begin
          add_reply(mirror_store[mirror_front], bdeq_pkg::ST_OK, 1'b1);
          mirror_front = (mirror_front + 1) % DEPTH;
          mirror_count--;
        end else begin
          add_reply(mirror_store[(mirror_front + mirror_count - 1) % DEPTH],
                    bdeq_pkg::ST_OK, 1'b1);
          mirror_count--;
        end
      end
      bdeq_pkg::MODE_LIST: begin
        list_count++;
        if (mirror_count == 0) begin
          add_reply('0, bdeq_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < mirror_count; i++)
            add_reply(mirror_store[(mirror_front + i) % DEPTH], bdeq_pkg::ST_OK,
                      i == mirror_count - 1);
        end
      end
      default: add_reply('0, bdeq_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  // Offer one request word; on acceptance queue its reply words.
  task automatic send_word(bdeq_pkg::mode_t mode, bdeq_pkg::data_t value, logic typed,
                           bdeq_pkg::data_t exp_item, bdeq_pkg::status_t exp_status);
    reply_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_replies(mode, value);
    if (typed) begin
      r.item = exp_item;
      r.status = exp_status;
      r.last = 1'b1;
      queued_replies.push_back(r);
    end else begin
      foreach (fresh_replies[i]) queued_replies.push_back(fresh_replies[i]);
    end
  endtask

  // sender holds off until every reply word is back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (queued_replies.size() != 0) @(posedge clk);
  endtask

  function automatic bdeq_pkg::data_t pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // filling bursts lean toward pushes to reach full, draining ones toward pops
  function automatic bdeq_pkg::mode_t pick_mode(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < (filling ? 70 : 15))
      return $urandom_range(1) ? bdeq_pkg::MODE_PUSH_FRONT : bdeq_pkg::MODE_PUSH_BACK;
    if (r < 85)
      return $urandom_range(1) ? bdeq_pkg::MODE_POP_FRONT : bdeq_pkg::MODE_POP_BACK;
    if (r < 96)
      return bdeq_pkg::MODE_LIST;
    case ($urandom_range(2))
      0: return MODE_SPARE_A;
      1: return MODE_SPARE_B;
      default: return MODE_SPARE_C;
    endcase
  endfunction

  // receiver: random stall, reply check, stuck watchdog
  always @(posedge clk) begin
    reply_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      word_count++;
      if (queued_replies.size() == 0) begin
        $error("unexpected reply word: item %h status %0d last %0b",
               out_tdata, out_tuser, out_tlast);
        err_count++;
      end else begin
        want = queued_replies.pop_front();
        if (out_tdata !== want.item) begin
          $error("item mismatch: expected %h, got %h", want.item, out_tdata);
          err_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_tuser);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, out_tlast);
          err_count++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: watchdog expired with %0d reply words outstanding",
               queued_replies.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    bit filling;
    bdeq_pkg::mode_t mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed steps
    foreach (plan[k]) begin
      for (int j = 0; j < plan[k].reps; j++)
        send_word(plan[k].mode, plan[k].value + bdeq_pkg::data_t'(j), plan[k].typed,
                  plan[k].exp_item, plan[k].exp_status);
    end
    drain_replies();

    // random traffic, one phase per idle/stall profile
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        filling = ((n / BURST_LEN) % 2 == 0) ^ ph[0];
        mode = pick_mode(filling);
        send_word(mode, pick_value(), 1'b0, '0, bdeq_pkg::ST_OK);
      end
      drain_replies();
    end

    // a list streams up to DEPTH words; leave room for any stray ones
    repeat (2 * DEPTH + 8) @(posedge clk);
    $display("tb: %0d requests (%0d lists), %0d reply words checked",
             req_count, list_count, word_count);
    $display("tb: %0d full pushes, %0d empty pops/lists", full_count, empty_count);
    if (err_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
